// ===== rtl/ordered_key_list_engine_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Ordered key list engine assertion macros
// Shared concurrent assertion forms used by the RTL of the list engine.
// ----------------------------------------------------------------------------
`ifndef ORDERED_KEY_LIST_ENGINE_UNIT_DEFINES_SVH
`define ORDERED_KEY_LIST_ENGINE_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define OKL_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define OKL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define OKL_ASSERT(lbl, cond, msg)
`define OKL_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/okl_pkg.sv =====
// ----------------------------------------------------------------------------
// Ordered key list engine package
// Sizes, command and status codes, sequencer states and shared structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package okl_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int LEN_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 32;
  localparam int POS_W    = 6;

  typedef enum logic [2:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_INS_BEFORE = 3'd1,
    CMD_ORD_INSERT = 3'd2,
    CMD_DELETE     = 3'd3,
    CMD_CLEAR      = 3'd4,
    CMD_FIND       = 3'd5,
    CMD_DUMP       = 3'd6,
    CMD_NOP        = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_NOT_FOUND = 2'd1,
    STS_FULL      = 2'd2,
    STS_EMPTY     = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_SEARCH,
    S_ACT,
    S_SHIFT_UP,
    S_PUT,
    S_SHIFT_DN,
    S_DUMP,
    S_REPLY
  } state_t;

  typedef struct packed {
    status_t                  status;
    logic signed [KEY_W-1:0]  key;
    logic        [POS_W-1:0]  pos;
    logic                     last;
  } res_t;

  typedef struct packed {
    logic             busy;
    logic [LEN_W-1:0] len;
  } stat_t;

endpackage

`default_nettype wire

// ===== rtl/okl_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered, enabled read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module okl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/okl_key_cmp.sv =====
// ----------------------------------------------------------------------------
// Ordered key list key comparator
// Shared compare unit: equality for searches, signed greater-than for
// ordered insertion.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module okl_key_cmp (
  input  wire logic                           ordered,
  input  wire logic signed [okl_pkg::KEY_W-1:0] entry,
  input  wire logic signed [okl_pkg::KEY_W-1:0] key,
  output      logic                           hit
);

  import okl_pkg::*;

  always_comb begin
    if (ordered) begin
      hit = (entry > key);
    end else begin
      hit = (entry == key);
    end
  end

endmodule

`default_nettype wire

// ===== rtl/okl_ctrl.sv =====
// ----------------------------------------------------------------------------
// Ordered key list sequencer
// Walks the key memory one entry per cycle to search, shift and dump (a dump
// waits while the output register is not free), and keeps the list length.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module okl_ctrl (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  input  wire okl_pkg::cmd_t                   in_cmd,
  input  wire logic signed [okl_pkg::KEY_W-1:0] in_mkey,
  input  wire logic signed [okl_pkg::KEY_W-1:0] in_val,
  input  wire logic                            out_free,
  output      logic                            res_valid,
  output      okl_pkg::res_t                   res,
  output      okl_pkg::stat_t                  stat,
  output      logic                            rd_en,
  output      logic [okl_pkg::ADDR_W-1:0]      rd_addr,
  input  wire logic signed [okl_pkg::KEY_W-1:0] rd_data,
  output      logic                            wr_en,
  output      logic [okl_pkg::ADDR_W-1:0]      wr_addr,
  output      logic signed [okl_pkg::KEY_W-1:0] wr_data
);

  import okl_pkg::*;

  state_t                  state;
  state_t                  state_next;
  cmd_t                    cmd;
  logic signed [KEY_W-1:0] mkey;
  logic signed [KEY_W-1:0] val;
  logic [ADDR_W-1:0]       idx;
  logic [LEN_W-1:0]        len;
  logic [LEN_W-1:0]        pos;
  logic                    found;
  status_t                 rep_status;
  logic signed [KEY_W-1:0] rep_key;

  logic                    hit;
  logic                    ordered;
  logic [LEN_W-1:0]        idx_ext;
  logic [LEN_W-1:0]        idx_inc;
  logic [LEN_W-1:0]        idx_inc2;
  logic [LEN_W-1:0]        pos_inc;
  logic [LEN_W-1:0]        len_dec;
  logic                    is_end;
  logic                    full;
  logic                    empty;
  logic                    ins_go;

  assign ordered  = (cmd == CMD_ORD_INSERT);
  assign idx_ext  = LEN_W'(idx);
  assign idx_inc  = idx_ext + LEN_W'(1);
  assign idx_inc2 = idx_ext + LEN_W'(2);
  assign pos_inc  = pos + LEN_W'(1);
  assign len_dec  = len - LEN_W'(1);
  assign is_end   = (idx_inc == len);
  assign full     = (len >= LEN_W'(CAPACITY));
  assign empty    = (len == '0);
  assign ins_go   = (cmd == CMD_PUSH_FRONT) || (cmd == CMD_ORD_INSERT) ||
                    ((cmd == CMD_INS_BEFORE) && found);

  assign stat.busy = (state != S_IDLE);
  assign stat.len  = len;

  okl_key_cmp u_cmp (
    .ordered (ordered),
    .entry   (rd_data),
    .key     (ordered ? val : mkey),
    .hit     (hit)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_START;
        end
      end
      S_START: begin
        unique case (cmd) inside
          CMD_PUSH_FRONT: begin
            state_next = full ? S_REPLY : S_ACT;
          end
          CMD_INS_BEFORE, CMD_ORD_INSERT: begin
            if (full) begin
              state_next = S_REPLY;
            end else if (empty) begin
              state_next = S_ACT;
            end else begin
              state_next = S_SEARCH;
            end
          end
          CMD_DELETE, CMD_FIND: begin
            state_next = empty ? S_REPLY : S_SEARCH;
          end
          CMD_DUMP: begin
            state_next = empty ? S_REPLY : S_DUMP;
          end
          default: begin
            state_next = S_REPLY;
          end
        endcase
      end
      S_SEARCH: begin
        if (hit || is_end) begin
          state_next = S_ACT;
        end
      end
      S_ACT: begin
        if (ins_go) begin
          state_next = (pos == len) ? S_PUT : S_SHIFT_UP;
        end else if ((cmd == CMD_DELETE) && found && (pos_inc < len)) begin
          state_next = S_SHIFT_DN;
        end else begin
          state_next = S_REPLY;
        end
      end
      S_SHIFT_UP: begin
        if (idx_ext == pos) begin
          state_next = S_PUT;
        end
      end
      S_PUT: begin
        state_next = S_REPLY;
      end
      S_SHIFT_DN: begin
        if (!(idx_inc2 < len)) begin
          state_next = S_REPLY;
        end
      end
      S_DUMP: begin
        if (out_free && is_end) begin
          state_next = S_IDLE;
        end
      end
      S_REPLY: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    rd_en      = 1'b0;
    rd_addr    = idx;
    wr_en      = 1'b0;
    wr_addr    = idx;
    wr_data    = rd_data;
    res_valid  = 1'b0;
    res.status = rep_status;
    res.key    = rep_key;
    res.pos    = POS_W'(pos);
    res.last   = 1'b1;
    unique case (state)
      S_START: begin
        if ((state_next == S_SEARCH) || (state_next == S_DUMP)) begin
          rd_en   = 1'b1;
          rd_addr = '0;
        end
      end
      S_SEARCH: begin
        if (!(hit || is_end)) begin
          rd_en   = 1'b1;
          rd_addr = idx_inc[ADDR_W-1:0];
        end
      end
      S_ACT: begin
        if (state_next == S_SHIFT_UP) begin
          rd_en   = 1'b1;
          rd_addr = len_dec[ADDR_W-1:0];
        end else if (state_next == S_SHIFT_DN) begin
          rd_en   = 1'b1;
          rd_addr = pos_inc[ADDR_W-1:0];
        end
      end
      S_SHIFT_UP: begin
        wr_en   = 1'b1;
        wr_addr = idx_inc[ADDR_W-1:0];
        if (idx_ext != pos) begin
          rd_en   = 1'b1;
          rd_addr = idx - ADDR_W'(1);
        end
      end
      S_PUT: begin
        wr_en   = 1'b1;
        wr_addr = pos[ADDR_W-1:0];
        wr_data = val;
      end
      S_SHIFT_DN: begin
        wr_en = 1'b1;
        if (idx_inc2 < len) begin
          rd_en   = 1'b1;
          rd_addr = idx_inc2[ADDR_W-1:0];
        end
      end
      S_DUMP: begin
        res_valid  = out_free;
        res.status = STS_OK;
        res.key    = rd_data;
        res.pos    = POS_W'(idx);
        res.last   = is_end;
        if (out_free && !is_end) begin
          rd_en   = 1'b1;
          rd_addr = idx_inc[ADDR_W-1:0];
        end
      end
      S_REPLY: begin
        res_valid = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      len   <= '0;
    end else begin
      state <= state_next;
      if ((state == S_START) && (cmd == CMD_CLEAR)) begin
        len <= '0;
      end else if (state == S_PUT) begin
        len <= len + LEN_W'(1);
      end else if ((state == S_ACT) && (cmd == CMD_DELETE) && found &&
                   (state_next == S_REPLY)) begin
        len <= len_dec;
      end else if ((state == S_SHIFT_DN) && (state_next == S_REPLY)) begin
        len <= len_dec;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd  <= in_cmd;
          mkey <= in_mkey;
          val  <= in_val;
        end
      end
      S_START: begin
        pos     <= '0;
        idx     <= '0;
        found   <= 1'b0;
        rep_key <= '0;
        if (((cmd == CMD_PUSH_FRONT) || (cmd == CMD_INS_BEFORE) ||
             (cmd == CMD_ORD_INSERT)) && full) begin
          rep_status <= STS_FULL;
        end else if (((cmd == CMD_DELETE) || (cmd == CMD_FIND) ||
                      (cmd == CMD_DUMP)) && empty) begin
          rep_status <= STS_EMPTY;
        end else begin
          rep_status <= STS_OK;
        end
      end
      S_SEARCH: begin
        if (hit) begin
          pos   <= idx_ext;
          found <= 1'b1;
        end else if (is_end) begin
          pos <= len;
        end else begin
          idx <= idx + ADDR_W'(1);
        end
      end
      S_ACT: begin
        if (state_next == S_SHIFT_UP) begin
          idx <= len_dec[ADDR_W-1:0];
        end else if (state_next == S_SHIFT_DN) begin
          idx <= pos[ADDR_W-1:0];
        end else if (state_next == S_REPLY) begin
          if (found) begin
            rep_status <= STS_OK;
            if (cmd == CMD_FIND) begin
              rep_key <= rd_data;
            end
          end else begin
            rep_status <= STS_NOT_FOUND;
            pos        <= '0;
          end
        end
      end
      S_SHIFT_UP: begin
        idx <= idx - ADDR_W'(1);
      end
      S_SHIFT_DN: begin
        idx <= idx + ADDR_W'(1);
      end
      S_DUMP: begin
        if (out_free && !is_end) begin
          idx <= idx + ADDR_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/ordered_key_list_engine_unit.sv =====
// ----------------------------------------------------------------------------
// Ordered key list engine
// A bounded list of up to 64 signed 32-bit keys with push, keyed and ordered
// insertion, delete, clear, find and dump, behind stream ports.
// ----------------------------------------------------------------------------
// The block takes one command word at a time and is not ready again until
// its last result word has been loaded into the output register. The keys
// sit in a single memory with one read and one write port, and the sequencer
// touches one entry per cycle, save where a dump waits on the output side:
// a search walks the entries in order until a hit or the list end, and an
// insert or delete then moves the entries behind the position one at a
// time. A dump delivers one word per cycle while the output side keeps
// taking them. Clear, and any command refused on a full or empty list, go
// straight to the reply without touching the memory.
`timescale 1ns / 1ps
`default_nettype none
`include "ordered_key_list_engine_unit_defines.svh"

module ordered_key_list_engine_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [71:0] s_tdata,   // cmd[2:0], match_key[34:3], value[66:35], zeros
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  output      logic [39:0] m_tdata,   // status[1:0], entry_key[33:2], position[39:34]
  output      logic        m_tlast
);

  import okl_pkg::*;

  logic                    res_valid;
  res_t                    res;
  stat_t                   stat;
  res_t                    out_res;
  logic                    out_free;
  logic                    rd_en;
  logic [ADDR_W-1:0]       rd_addr;
  logic signed [KEY_W-1:0] rd_data;
  logic                    wr_en;
  logic [ADDR_W-1:0]       wr_addr;
  logic signed [KEY_W-1:0] wr_data;

  assign s_tready = !stat.busy;
  assign out_free = !m_tvalid || m_tready;

  okl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_cmd    (cmd_t'(s_tdata[2:0])),
    .in_mkey   (s_tdata[34:3]),
    .in_val    (s_tdata[66:35]),
    .out_free  (out_free),
    .res_valid (res_valid),
    .res       (res),
    .stat      (stat),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  okl_ram #(
    .WIDTH (KEY_W),
    .DEPTH (CAPACITY)
  ) u_keys (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res <= res;
    end
  end

  assign m_tdata = {out_res.pos, out_res.key, out_res.status};
  assign m_tlast = out_res.last;

  `OKL_ASSERT(a_len_bound, stat.len <= LEN_W'(CAPACITY), "list length beyond capacity")
  `OKL_ASSERT(a_res_slot, !res_valid || !m_tvalid || m_tready, "result word overwrites a pending word")
  `OKL_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready stayed high after accept")

endmodule

`default_nettype wire
